// File: design/hsl_to_rgb_converter_assert.svh
// Assertion macros shared by the HSL to RGB converter modules.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication
`define H2R_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/h2r_pkg.sv
// Shared types and fixed field widths of the HSL to RGB converter.
// Used by h2r_prep, h2r_scale and the top module; depends on nothing.
package h2r_pkg;

   localparam int HUE_W   = 12;
   localparam int UNIT_W  = 13;
   localparam int CHAN_W  = 8;
   localparam int NUM_CH  = 3;

   // channel slots in the per-channel arrays
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [UNIT_W-1:0] saturation;
      logic [UNIT_W-1:0] lightness;
      logic [CHAN_W-1:0] alpha_in;
   } in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha_out;
   } out_type;

endpackage

// File: design/h2r_prep.sv
// Front end of the converter: input clamping, hue thirds, chroma product and
// per-channel segment weights, two register stages. Uses h2r_pkg types.
`include "hsl_to_rgb_converter_assert.svh"

module h2r_prep #(
   parameter int FRAC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  h2r_pkg::in_type        in_data,
   output logic                   out_valid,
   output logic [h2r_pkg::CHAN_W-1:0] out_alpha,
   output logic [FRAC_BITS:0]     out_l,
   output logic [2*FRAC_BITS-1:0] out_sm,
   output logic signed [FRAC_BITS+1:0] out_k [h2r_pkg::NUM_CH]
);

   localparam int F   = FRAC_BITS;
   localparam int HW  = (F > h2r_pkg::HUE_W) ? F : h2r_pkg::HUE_W;
   localparam int CW  = (F + 1 > h2r_pkg::UNIT_W) ? F + 1 : h2r_pkg::UNIT_W;
   localparam int TW  = F + 3;
   localparam int KW  = F + 5;

   localparam logic [F:0]    ONE      = {1'b1, {F{1'b0}}};
   localparam logic [F:0]    HALF     = ONE >> 1;
   localparam logic [CW-1:0] ONE_C    = CW'(ONE);
   localparam logic [TW-1:0] ONE_T    = TW'(1) << F;
   localparam logic [TW-1:0] TURN3    = TW'(3) << F;
   localparam logic [F+1:0]  SEG_RISE = (F+2)'(1) << (F - 1);
   localparam logic [F+1:0]  SEG_FLAT = (F+2)'(3) << (F - 1);
   localparam logic [F+1:0]  SEG_FALL = (F+2)'(2) << F;
   localparam logic signed [KW-1:0] ONE_K   = KW'(1) << F;
   localparam logic signed [KW-1:0] SEVEN_K = KW'(7) << F;
   localparam logic [2*F-1:0] SM_MAX = (2*F)'(1) << (2*F - 1);
   localparam logic signed [F+1:0] K_LIM = (F+2)'(1) << F;

   // stage 1 signals
   logic [HW-1:0] hue_wide;
   logic [F-1:0]  h;
   logic [CW-1:0] sat_wide;
   logic [CW-1:0] lit_wide;
   logic [F:0]    s_c;
   logic [F:0]    l_c;
   logic [F:0]    m_diff;
   logic [TW-1:0] t3;
   logic [TW-1:0] tr_sum;
   logic [TW-1:0] tb_sum;
   logic [TW-1:0] tr_wrap;
   logic [TW-1:0] tb_wrap;

   logic          valid1_ff;
   logic [h2r_pkg::CHAN_W-1:0] alpha1_ff;
   logic [F:0]    s1_ff;
   logic [F:0]    l1_ff;
   logic [F-1:0]  m1_ff;
   logic [F-1:0]  m1_in;
   logic [F+1:0]  t1_ff [h2r_pkg::NUM_CH];

   // stage 2 signals
   logic [2*F:0]  sm_full;
   logic signed [KW-1:0]  k_calc [h2r_pkg::NUM_CH];
   logic signed [F+1:0]   k_in   [h2r_pkg::NUM_CH];

   logic          valid2_ff;
   logic [h2r_pkg::CHAN_W-1:0] alpha2_ff;
   logic [F:0]    l2_ff;
   logic [2*F-1:0] sm2_ff;
   logic signed [F+1:0] k2_ff [h2r_pkg::NUM_CH];
   logic          k2_ok;

   // clamp saturation and lightness to one, keep the low hue bits
   always_comb begin
      hue_wide = HW'(in_data.hue);
      h        = hue_wide[F-1:0];
      sat_wide = CW'(in_data.saturation);
      lit_wide = CW'(in_data.lightness);
      s_c      = (sat_wide > ONE_C) ? ONE : sat_wide[F:0];
      l_c      = (lit_wide > ONE_C) ? ONE : lit_wide[F:0];
   end

   // distance of lightness from the nearer end, never above one half
   always_comb begin
      m_diff = ONE - l_c;
      m1_in  = (l_c < HALF) ? l_c[F-1:0] : m_diff[F-1:0];
   end

   // tripled hue and its shifts by a third of a turn, wrapped
   always_comb begin
      t3      = TW'(h) + (TW'(h) << 1);
      tr_sum  = t3 + ONE_T;
      tb_sum  = t3 + (ONE_T << 1);
      tr_wrap = (tr_sum >= TURN3) ? tr_sum - TURN3 : tr_sum;
      tb_wrap = (tb_sum >= TURN3) ? tb_sum - TURN3 : tb_sum;
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      alpha1_ff                    <= in_data.alpha_in;
      s1_ff                        <= s_c;
      l1_ff                        <= l_c;
      m1_ff                        <= m1_in;
      t1_ff[h2r_pkg::CH_RED]       <= tr_wrap[F+1:0];
      t1_ff[h2r_pkg::CH_GREEN]     <= t3[F+1:0];
      t1_ff[h2r_pkg::CH_BLUE]      <= tb_wrap[F+1:0];
   end

   // chroma half-width s*m, scale one squared
   assign sm_full = (2*F+1)'(s1_ff) * (2*F+1)'(m1_ff);

   // segment weight per channel: -one at p, +one at q, linear in between
   always_comb begin
      for (int i = 0; i < h2r_pkg::NUM_CH; i++) begin
         if (t1_ff[i] < SEG_RISE) begin
            k_calc[i] = ($signed({3'b000, t1_ff[i]}) <<< 2) - ONE_K;
         end else if (t1_ff[i] < SEG_FLAT) begin
            k_calc[i] = ONE_K;
         end else if (t1_ff[i] < SEG_FALL) begin
            k_calc[i] = SEVEN_K - ($signed({3'b000, t1_ff[i]}) <<< 2);
         end else begin
            k_calc[i] = -ONE_K;
         end
         k_in[i] = k_calc[i][F+1:0];
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      alpha2_ff <= alpha1_ff;
      l2_ff     <= l1_ff;
      sm2_ff    <= sm_full[2*F-1:0];
      for (int i = 0; i < h2r_pkg::NUM_CH; i++) begin
         k2_ff[i] <= k_in[i];
      end
   end

   assign out_valid = valid2_ff;
   assign out_alpha = alpha2_ff;
   assign out_l     = l2_ff;
   assign out_sm    = sm2_ff;
   always_comb begin
      for (int i = 0; i < h2r_pkg::NUM_CH; i++) begin
         out_k[i] = k2_ff[i];
      end
   end

   // every stored weight within plus or minus one
   always_comb begin
      k2_ok = 1'b1;
      for (int i = 0; i < h2r_pkg::NUM_CH; i++) begin
         if ((k2_ff[i] > K_LIM) || (k2_ff[i] < -K_LIM)) begin
            k2_ok = 1'b0;
         end
      end
   end

   // checks
   `H2R_ASSERT_NEXT(a_valid_moves, valid1_ff, valid2_ff, "stage valid lost in front end")
   `H2R_ASSERT_IMPLIES(a_k_range, valid2_ff, k2_ok, "segment weight out of range")
   `H2R_ASSERT_IMPLIES(a_sm_range, valid2_ff, (sm2_ff <= SM_MAX), "chroma product above one half")

endmodule

// File: design/h2r_blend.sv
// One channel's blend of lightness and weighted chroma: v = l*one^2 + s*m*k,
// two register stages (multiply, then add). No package dependency.
module h2r_blend #(
   parameter int FRAC_BITS = 12
) (
   input  logic                        clock,
   input  logic [2*FRAC_BITS-1:0]      sm,
   input  logic signed [FRAC_BITS+1:0] k,
   input  logic [FRAC_BITS:0]          l,
   output logic [3*FRAC_BITS:0]        v
);

   localparam int F = FRAC_BITS;

   logic signed [3*F+2:0] prod_full;
   logic signed [3*F:0]   prod_ff;
   logic [F:0]            l_ff;
   logic signed [3*F+1:0] sum;
   logic [3*F:0]          v_ff;

   // signed chroma term at scale one cubed, magnitude at most one half
   assign prod_full = $signed({1'b0, sm}) * k;

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[3*F:0];
      l_ff    <= l;
   end

   // add lightness at scale one cubed; result never negative
   assign sum = $signed({1'b0, l_ff, {(2*F){1'b0}}}) + prod_ff;

   always_ff @(posedge clock) begin
      v_ff <= sum[3*F:0];
   end

   assign v = v_ff;

endmodule

// File: design/h2r_scale.sv
// One channel's output scaling: times the channel maximum, round half up,
// saturate and fit the 8-bit field; two register stages. Uses h2r_pkg widths.
module h2r_scale #(
   parameter int FRAC_BITS    = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                         clock,
   input  logic [3*FRAC_BITS:0]         v,
   output logic [h2r_pkg::CHAN_W-1:0]   chan
);

   localparam int F  = FRAC_BITS;
   localparam int CB = CHANNEL_BITS;
   localparam int XW = 3*F + CB + 1;
   localparam int OW = (CB > h2r_pkg::CHAN_W) ? CB : h2r_pkg::CHAN_W;
   localparam logic [XW-1:0] ROUND_HALF = XW'(1) << (3*F - 1);
   localparam logic [CB:0]   CH_MAX     = {1'b0, {CB{1'b1}}};

   logic [XW-1:0] v_wide;
   logic [XW-1:0] x_ff;
   logic [CB:0]   c;
   logic [CB-1:0] c_sat;
   logic [OW-1:0] c_wide;
   logic [h2r_pkg::CHAN_W-1:0] chan_ff;

   // v*(2^CB - 1) + half as shift and subtract
   assign v_wide = XW'(v);

   always_ff @(posedge clock) begin
      x_ff <= (v_wide << CB) - v_wide + ROUND_HALF;
   end

   // drop the fraction, clip at the channel maximum, keep the field bits
   always_comb begin
      c      = x_ff[XW-1:3*F];
      c_sat  = (c > CH_MAX) ? CH_MAX[CB-1:0] : c[CB-1:0];
      c_wide = OW'(c_sat);
   end

   always_ff @(posedge clock) begin
      chan_ff <= c_wide[h2r_pkg::CHAN_W-1:0];
   end

   assign chan = chan_ff;

endmodule

// File: design/hsl_to_rgb_converter.sv
// HSL to RGB converter, fully pipelined: one pixel may be started in every clock
// cycle and busy never rises. Each result is shown for one cycle with rsp_valid
// high, in start order; the receiver cannot hold it off, so it must take rsp_data
// in that cycle. The six stages are two of clamping, hue thirds and chroma product,
// two of the per-channel blend multiply and add, and two of the per-channel
// rounding; the two multiplier stages set the clock. Zero saturation gives gray
// at the lightness value. Uses h2r_pkg.
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter #(
   parameter int FRAC_BITS    = 12,
   parameter int CHANNEL_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   output logic             busy,
   input  h2r_pkg::in_type  req_data,
   output logic             rsp_valid,
   output h2r_pkg::out_type rsp_data
);

   localparam int F         = FRAC_BITS;
   localparam int TAIL      = 4;
   localparam int LATENCY   = 2 + TAIL;

   logic                        accept;
   logic                        prep_valid;
   logic [h2r_pkg::CHAN_W-1:0]  prep_alpha;
   logic [F:0]                  prep_l;
   logic [2*F-1:0]              prep_sm;
   logic signed [F+1:0]         prep_k [h2r_pkg::NUM_CH];
   logic [3*F:0]                blend_v [h2r_pkg::NUM_CH];
   logic [h2r_pkg::CHAN_W-1:0]  chan [h2r_pkg::NUM_CH];

   logic                        valid_pipe_ff [TAIL];
   logic [h2r_pkg::CHAN_W-1:0]  alpha_pipe_ff [TAIL];

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   h2r_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_alpha (prep_alpha),
      .out_l     (prep_l),
      .out_sm    (prep_sm),
      .out_k     (prep_k)
   );

   // per-channel blend and scaling
   for (genvar i = 0; i < h2r_pkg::NUM_CH; i++) begin : g_chan
      h2r_blend #(
         .FRAC_BITS (FRAC_BITS)
      ) u_blend (
         .clock (clock),
         .sm    (prep_sm),
         .k     (prep_k[i]),
         .l     (prep_l),
         .v     (blend_v[i])
      );

      h2r_scale #(
         .FRAC_BITS    (FRAC_BITS),
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_scale (
         .clock (clock),
         .v     (blend_v[i]),
         .chan  (chan[i])
      );
   end

   // valid and alpha ride alongside the channel stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL; i++) begin
            valid_pipe_ff[i] <= 1'b0;
         end
      end else begin
         valid_pipe_ff[0] <= prep_valid;
         for (int i = 1; i < TAIL; i++) begin
            valid_pipe_ff[i] <= valid_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      alpha_pipe_ff[0] <= prep_alpha;
      for (int i = 1; i < TAIL; i++) begin
         alpha_pipe_ff[i] <= alpha_pipe_ff[i-1];
      end
   end

   // result transfer
   assign rsp_valid          = valid_pipe_ff[TAIL-1];
   assign rsp_data.red       = chan[h2r_pkg::CH_RED];
   assign rsp_data.green     = chan[h2r_pkg::CH_GREEN];
   assign rsp_data.blue      = chan[h2r_pkg::CH_BLUE];
   assign rsp_data.alpha_out = alpha_pipe_ff[TAIL-1];

   // checks
   `H2R_ASSERT_IMPLIES(a_rsp_latency, rsp_valid, $past(accept, LATENCY), "result without a start")
   `H2R_ASSERT_IMPLIES(a_alpha_copy, rsp_valid, (rsp_data.alpha_out == $past(req_data.alpha_in, LATENCY)), "alpha not carried with its pixel")
   `H2R_ASSERT_IMPLIES(a_gray, (rsp_valid && ($past(req_data.saturation, LATENCY) == '0)), ((rsp_data.red == rsp_data.green) && (rsp_data.green == rsp_data.blue)), "zero saturation not gray")

endmodule
